[sv/rcst_pkg.sv]
// Shared types and constants of the row and column swap table.
package rcst_pkg;

   localparam int INDEX_W    = 6;
   localparam int VALUE_W    = 32;
   localparam int LIMIT_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;
   localparam int MAP_REACH  = 64;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [REQ_USER_W-1:0] {
      CMD_LOAD      = 2'd0,
      CMD_SWAP_ROWS = 2'd1,
      CMD_SWAP_COLS = 2'd2,
      CMD_GET       = 2'd3
   } command_type;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MAP    = 4'b0010,
      ST_WRB    = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

endpackage

[sv/row_column_swap_table.sv]
// Top level of the row and column swap table with its remap and cell memories.
//
// A table of 32-bit cells reached through a row remap and a column remap, both
// reset to the identity. The command is on req_tuser and the operands on
// req_tdata. A load writes the cell memory directly. In a swap, both remap
// entries are read in the memory's two read ports, then written back one per
// cycle through its single write port. In a get, the row and column remaps
// are read together, then the cell memory, then the result is placed in the
// output register; an out-of-range get goes straight to the result state and
// answers zero with the error flag. An item is accepted only when the previous
// one is finished, and a result waiting on rsp_tready holds back only the next
// get. No clearing pass is needed after reset; configuration writes are taken
// in every cycle.
module row_column_swap_table #(
   parameter int ROWS = 64,
   parameter int COLS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: first_index, second_index, cell_value, zero fill.
   input  logic [rcst_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Field: command.
   input  logic [rcst_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Field: read_value.
   output logic [rcst_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Field: index_error.
   output logic [rcst_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rcst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcst_pkg::LIMIT_W-1:0]       csr_data
);

   localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW       = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int MAP_ROWS = (ROWS < rcst_pkg::MAP_REACH) ? ROWS : rcst_pkg::MAP_REACH;
   localparam int MAP_COLS = (COLS < rcst_pkg::MAP_REACH) ? COLS : rcst_pkg::MAP_REACH;
   localparam int MRW      = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int MCW      = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
   localparam int CELLS    = ROWS * COLS;
   localparam int CAW      = $clog2(CELLS);
   localparam logic [31:0] ROWS_U = 32'(ROWS);
   localparam logic [31:0] COLS_U = 32'(COLS);

   localparam int IW = rcst_pkg::INDEX_W;
   localparam int VW = rcst_pkg::VALUE_W;

   // Memories.
   logic [RW-1:0] row_map_mem [MAP_ROWS];
   logic [CW-1:0] col_map_mem [MAP_COLS];
   logic [VW-1:0] cell_mem    [CELLS];

   rcst_pkg::state_type state_ff, state_in;

   logic [rcst_pkg::LIMIT_W-1:0] rows_ff, cols_ff;
   logic [MAP_ROWS-1:0]          row_vld_ff;
   logic [MAP_COLS-1:0]          col_vld_ff;

   rcst_pkg::command_type cmd_ff;
   logic [IW-1:0]         a_ff, b_ff;
   logic                  err_ff;

   logic [RW-1:0] row_q0_ff, row_q1_ff, row_tmp_ff;
   logic [CW-1:0] col_q0_ff, col_q1_ff, col_tmp_ff;
   logic          row_v0_ff, row_v1_ff, col_v0_ff, col_v1_ff;
   logic [VW-1:0] cell_q_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_data_ff;
   logic          rsp_err_ff;

   rcst_pkg::command_type req_cmd;
   logic [IW-1:0]         req_a, req_b, col_rd0_idx, col_id0_idx;
   logic [VW-1:0]         req_value;
   logic                  req_fire;
   logic                  a_row_ok, b_row_ok, a_col_ok, b_col_ok, op_ok;
   logic [RW-1:0]         row_val0, row_val1;
   logic [CW-1:0]         col_val0, col_val1;
   logic                  row_we, col_we, cell_we, map_rd, cell_re, rsp_load;
   logic [MRW-1:0]        row_wa;
   logic [RW-1:0]         row_wd;
   logic [MCW-1:0]        col_wa;
   logic [CW-1:0]         col_wd;
   logic [CAW-1:0]        cell_wa, cell_ra;

   assign req_cmd   = rcst_pkg::command_type'(req_tuser);
   assign req_a     = req_tdata[IW-1:0];
   assign req_b     = req_tdata[2*IW-1:IW];
   assign req_value = req_tdata[2*IW+VW-1:2*IW];

   assign req_tready = (state_ff == rcst_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign a_row_ok = (7'(req_a) < rows_ff) && (32'(req_a) < ROWS_U);
   assign b_row_ok = (7'(req_b) < rows_ff) && (32'(req_b) < ROWS_U);
   assign a_col_ok = (7'(req_a) < cols_ff) && (32'(req_a) < COLS_U);
   assign b_col_ok = (7'(req_b) < cols_ff) && (32'(req_b) < COLS_U);

   always_comb begin
      case (req_cmd)
         rcst_pkg::CMD_SWAP_ROWS: op_ok = a_row_ok && b_row_ok;
         rcst_pkg::CMD_SWAP_COLS: op_ok = a_col_ok && b_col_ok;
         default:                 op_ok = a_row_ok && b_col_ok;
      endcase
   end

   // Column port 0 serves the column of a get and the first entry of a swap.
   assign col_rd0_idx = (req_cmd == rcst_pkg::CMD_GET) ? req_b : req_a;
   assign col_id0_idx = (cmd_ff == rcst_pkg::CMD_GET) ? b_ff : a_ff;

   // An entry never written still holds its identity value.
   assign row_val0 = row_v0_ff ? row_q0_ff : RW'(a_ff);
   assign row_val1 = row_v1_ff ? row_q1_ff : RW'(b_ff);
   assign col_val0 = col_v0_ff ? col_q0_ff : CW'(col_id0_idx);
   assign col_val1 = col_v1_ff ? col_q1_ff : CW'(b_ff);

   assign map_rd  = req_fire;
   assign cell_we = req_fire && (req_cmd == rcst_pkg::CMD_LOAD) && op_ok;
   assign cell_wa = CAW'(req_a) * CAW'(COLS) + CAW'(req_b);
   assign cell_re = (state_ff == rcst_pkg::ST_MAP) && (cmd_ff == rcst_pkg::CMD_GET);
   assign cell_ra = CAW'(row_val0) * CAW'(COLS) + CAW'(col_val0);

   always_comb begin
      row_we = 1'b0;
      row_wa = MRW'(a_ff);
      row_wd = row_val1;
      col_we = 1'b0;
      col_wa = MCW'(a_ff);
      col_wd = col_val1;
      if (state_ff == rcst_pkg::ST_MAP) begin
         row_we = (cmd_ff == rcst_pkg::CMD_SWAP_ROWS);
         col_we = (cmd_ff == rcst_pkg::CMD_SWAP_COLS);
      end else if (state_ff == rcst_pkg::ST_WRB) begin
         row_we = (cmd_ff == rcst_pkg::CMD_SWAP_ROWS);
         col_we = (cmd_ff == rcst_pkg::CMD_SWAP_COLS);
         row_wa = MRW'(b_ff);
         row_wd = row_tmp_ff;
         col_wa = MCW'(b_ff);
         col_wd = col_tmp_ff;
      end
   end

   assign rsp_load = (state_ff == rcst_pkg::ST_RESULT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcst_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == rcst_pkg::CMD_GET) begin
                  state_in = op_ok ? rcst_pkg::ST_MAP : rcst_pkg::ST_RESULT;
               end else if (req_cmd != rcst_pkg::CMD_LOAD && op_ok) begin
                  state_in = rcst_pkg::ST_MAP;
               end
            end
         end
         rcst_pkg::ST_MAP: begin
            state_in = (cmd_ff == rcst_pkg::CMD_GET) ? rcst_pkg::ST_RESULT
                                                      : rcst_pkg::ST_WRB;
         end
         rcst_pkg::ST_WRB: begin
            state_in = rcst_pkg::ST_IDLE;
         end
         rcst_pkg::ST_RESULT: begin
            if (rsp_load) begin
               state_in = rcst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rcst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcst_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= rcst_pkg::LIMIT_RESET;
         cols_ff      <= rcst_pkg::LIMIT_RESET;
         row_vld_ff   <= '0;
         col_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               rcst_pkg::REG_ROWS_IN_USE: rows_ff <= csr_data;
               rcst_pkg::REG_COLS_IN_USE: cols_ff <= csr_data;
               default: ;
            endcase
         end
         if (row_we) begin
            row_vld_ff[row_wa] <= 1'b1;
         end
         if (col_we) begin
            col_vld_ff[col_wa] <= 1'b1;
         end
      end
   end

   // Item fields, the snapshot of the remap valid bits at read time, the swap holding values and the result.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= req_cmd;
         a_ff      <= req_a;
         b_ff      <= req_b;
         err_ff    <= !op_ok;
         row_v0_ff <= row_vld_ff[MRW'(req_a)];
         row_v1_ff <= row_vld_ff[MRW'(req_b)];
         col_v0_ff <= col_vld_ff[MCW'(col_rd0_idx)];
         col_v1_ff <= col_vld_ff[MCW'(req_b)];
      end
      if (state_ff == rcst_pkg::ST_MAP) begin
         row_tmp_ff <= row_val0;
         col_tmp_ff <= col_val0;
      end
      if (rsp_load) begin
         rsp_data_ff <= err_ff ? '0 : cell_q_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_map_mem[row_wa] <= row_wd;
      end
      if (map_rd) begin
         row_q0_ff <= row_map_mem[MRW'(req_a)];
         row_q1_ff <= row_map_mem[MRW'(req_b)];
      end
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_map_mem[col_wa] <= col_wd;
      end
      if (map_rd) begin
         col_q0_ff <= col_map_mem[MCW'(col_rd0_idx)];
         col_q1_ff <= col_map_mem[MCW'(req_b)];
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= req_value;
      end
      if (cell_re) begin
         cell_q_ff <= cell_mem[cell_ra];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("error result carries nonzero data");

   a_swap_wrb: assert property (@(posedge clock) disable iff (reset)
      state_ff == rcst_pkg::ST_MAP && cmd_ff != rcst_pkg::CMD_GET
      |=> state_ff == rcst_pkg::ST_WRB)
      else $error("swap skipped its second write");

   a_get_path: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_cmd == rcst_pkg::CMD_GET
      |=> state_ff == rcst_pkg::ST_MAP || state_ff == rcst_pkg::ST_RESULT)
      else $error("get item did not proceed toward a result");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == rcst_pkg::ST_RESULT))
      else $error("result appeared outside the result state");

endmodule
